>>> src/ir_alu_with_variable_file_defines.svh
// Assertion macros for the checker file of the IR ALU.
`ifndef IR_ALU_WITH_VARIABLE_FILE_DEFINES_SVH
`define IR_ALU_WITH_VARIABLE_FILE_DEFINES_SVH

// Clocked check, held off while reset is asserted, with a fixed report.
`define IRALU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iralu: port check failed");

// Clocked check, held off while reset is asserted, with a caller message.
`define IRALU_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> src/iralu_pkg.sv
// Types and operation codes of the IR ALU with variable file.
package iralu_pkg;

    localparam int DATA_W = 32;

    // Operation codes carried in the kind field.
    localparam logic [4:0] KIND_AND      = 5'd0;
    localparam logic [4:0] KIND_OR       = 5'd1;
    localparam logic [4:0] KIND_NOT      = 5'd2;
    localparam logic [4:0] KIND_XOR      = 5'd3;
    localparam logic [4:0] KIND_ADD      = 5'd4;
    localparam logic [4:0] KIND_ADD_LONG = 5'd5;
    localparam logic [4:0] KIND_SUB      = 5'd6;
    localparam logic [4:0] KIND_MUL      = 5'd7;
    localparam logic [4:0] KIND_MUL_LONG = 5'd8;
    localparam logic [4:0] KIND_LSL      = 5'd9;
    localparam logic [4:0] KIND_LSR      = 5'd10;
    localparam logic [4:0] KIND_ASR      = 5'd11;
    localparam logic [4:0] KIND_ROR      = 5'd12;
    localparam logic [4:0] KIND_BS_LSL   = 5'd13;
    localparam logic [4:0] KIND_BS_LSR   = 5'd14;
    localparam logic [4:0] KIND_BS_ASR   = 5'd15;
    localparam logic [4:0] KIND_BS_ROR   = 5'd16;
    localparam logic [4:0] KIND_RRX      = 5'd17;
    localparam logic [4:0] KIND_CLZ      = 5'd18;
    localparam logic [4:0] KIND_CMP      = 5'd19;
    localparam logic [4:0] KIND_COPY     = 5'd20;
    localparam logic [4:0] KIND_GETBIT   = 5'd21;
    localparam logic [4:0] KIND_SETBIT   = 5'd22;
    localparam logic [4:0] KIND_LAST     = KIND_SETBIT;

    // Compare types in the variant field.
    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GE = 2'd2;
    localparam logic [1:0] CMP_GT = 2'd3;

    typedef struct packed {
        logic [4:0]        kind;
        logic [5:0]        dest_index;
        logic [5:0]        dest2_index;
        logic              a_from_var;
        logic [DATA_W-1:0] a_operand;
        logic              b_from_var;
        logic [DATA_W-1:0] b_operand;
        logic              c_from_var;
        logic [DATA_W-1:0] c_operand;
        logic              d_from_var;
        logic [DATA_W-1:0] d_operand;
        logic [1:0]        variant;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] primary_value;
        logic [DATA_W-1:0] secondary_value;
        logic [1:0]        writes;
    } result_t;

    // Leading zero count by halving search; all zeros gives 32.
    function automatic logic [5:0] clz32(logic [31:0] v);
        logic [31:0] t;
        logic [5:0]  n;
        t = v;
        n = 6'd0;
        if (v == 32'd0) begin
            n = 6'd32;
        end
        else begin
            if (t[31:16] == 16'd0) begin
                n = n + 6'd16;
                t = t << 16;
            end
            if (t[31:24] == 8'd0) begin
                n = n + 6'd8;
                t = t << 8;
            end
            if (t[31:28] == 4'd0) begin
                n = n + 6'd4;
                t = t << 4;
            end
            if (t[31:30] == 2'd0) begin
                n = n + 6'd2;
                t = t << 2;
            end
            if (t[31] == 1'b0) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

endpackage

>>> src/ir_alu_with_variable_file.sv
// Top level of the IR ALU: executes one operation per word on a variable file.
//
// Command channel: a word on cmd is taken at a rising edge with start high and
// busy low. busy stays low, so a new word may be issued every cycle.
// Result channel: done is high for exactly one cycle with the result word on
// result; the receiver takes it at the edge that ends that cycle and cannot
// hold it off.
// Stages in order: index reduction, variable bank read, then execute and
// write back; throughput is one word per cycle.
// Up to two writes per word go to two banks; a per-entry select bit tells which
// bank holds the newest value. The word just written back is forwarded to the
// word behind it, so back-to-back dependent words see each other's results.
// Reset clears the pipeline valid bits only; variables are undefined until
// written and no clearing pass runs.
module ir_alu_with_variable_file #(
    parameter int VARIABLE_COUNT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  iralu_pkg::cmd_t    cmd,
    output logic               done,
    output iralu_pkg::result_t result
);

    localparam int IDX_W = $clog2(VARIABLE_COUNT);

    logic [3:0]            v_reg;
    iralu_pkg::cmd_t       s0_reg;
    iralu_pkg::cmd_t       s1_reg;
    iralu_pkg::cmd_t       s2_reg;
    iralu_pkg::cmd_t       s3_reg;

    logic [IDX_W-1:0]      idx_s2 [4];
    logic [IDX_W-1:0]      dest_s2;
    logic [IDX_W-1:0]      dest2_s2;
    logic [IDX_W-1:0]      idx_s3_reg [4];
    logic [IDX_W-1:0]      dest_s3_reg;
    logic [IDX_W-1:0]      dest2_s3_reg;

    logic [31:0]           p_rd [4];
    logic [31:0]           s_rd [4];
    logic                  lvt0_reg [VARIABLE_COUNT];
    logic                  lvt1_reg [VARIABLE_COUNT];
    logic                  lvt_rd_reg [4];
    logic                  same_dest;

    logic                  from_var [4];
    logic [31:0]           konst [4];
    logic [31:0]           opnd [4];
    logic [31:0]           a;
    logic [31:0]           b;
    logic [31:0]           c;
    logic [31:0]           d;

    logic                  mul_signed;
    logic signed [65:0]    mul_prod;
    logic [63:0]           sum_long;
    logic                  b_lt32;
    logic                  d_lt32;
    logic [31:0]           bs_n;
    logic                  bs_zero;
    logic                  bs_lt32;
    logic                  bs_le32;
    logic [32:0]           lsl_ext;
    logic [32:0]           lsr_ext;
    logic [31:0]           asr_val;
    logic [31:0]           fill;
    logic [63:0]           rot64;
    logic                  cmp_flag;

    logic [31:0]           p_val;
    logic [31:0]           s_val;
    logic [1:0]            w_cnt;
    logic                  we_p;
    logic                  we_s;

    logic                  done_reg;
    iralu_pkg::result_t    res_reg;
    logic [IDX_W-1:0]      fwd_dest_reg;
    logic [IDX_W-1:0]      fwd_dest2_reg;

    assign busy = 1'b0;

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[2:0], start & ~busy};
            done_reg <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= cmd;
        s1_reg <= s0_reg;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
    end

    // Index reduction for the four operands and both destinations.
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_a (
        .clk (clk), .x (s0_reg.a_operand), .idx (idx_s2[0])
    );
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_b (
        .clk (clk), .x (s0_reg.b_operand), .idx (idx_s2[1])
    );
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_c (
        .clk (clk), .x (s0_reg.c_operand), .idx (idx_s2[2])
    );
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_d (
        .clk (clk), .x (s0_reg.d_operand), .idx (idx_s2[3])
    );
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_dest (
        .clk (clk), .x (32'(s0_reg.dest_index)), .idx (dest_s2)
    );
    iralu_idx #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_idx_dest2 (
        .clk (clk), .x (32'(s0_reg.dest2_index)), .idx (dest2_s2)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            idx_s3_reg[i] <= idx_s2[i];
        end
        dest_s3_reg  <= dest_s2;
        dest2_s3_reg <= dest2_s2;
    end

    // Primary-result bank and secondary-result bank, each in two copies.
    iralu_mem #(.DEPTH(VARIABLE_COUNT)) u_mem_p0 (
        .clk (clk), .we (we_p), .waddr (dest_s3_reg), .wdata (p_val),
        .raddr0 (idx_s2[0]), .raddr1 (idx_s2[1]),
        .rdata0 (p_rd[0]), .rdata1 (p_rd[1])
    );
    iralu_mem #(.DEPTH(VARIABLE_COUNT)) u_mem_p1 (
        .clk (clk), .we (we_p), .waddr (dest_s3_reg), .wdata (p_val),
        .raddr0 (idx_s2[2]), .raddr1 (idx_s2[3]),
        .rdata0 (p_rd[2]), .rdata1 (p_rd[3])
    );
    iralu_mem #(.DEPTH(VARIABLE_COUNT)) u_mem_s0 (
        .clk (clk), .we (we_s), .waddr (dest2_s3_reg), .wdata (s_val),
        .raddr0 (idx_s2[0]), .raddr1 (idx_s2[1]),
        .rdata0 (s_rd[0]), .rdata1 (s_rd[1])
    );
    iralu_mem #(.DEPTH(VARIABLE_COUNT)) u_mem_s1 (
        .clk (clk), .we (we_s), .waddr (dest2_s3_reg), .wdata (s_val),
        .raddr0 (idx_s2[2]), .raddr1 (idx_s2[3]),
        .rdata0 (s_rd[2]), .rdata1 (s_rd[3])
    );

    assign same_dest = we_s && (dest_s3_reg == dest2_s3_reg);

    // Bank select per variable in two copies, read alongside the banks;
    // a secondary write lands last and wins.
    always_ff @(posedge clk)
    begin
        if (we_p && !same_dest)
        begin
            lvt0_reg[dest_s3_reg] <= 1'b0;
            lvt1_reg[dest_s3_reg] <= 1'b0;
        end
        if (we_s)
        begin
            lvt0_reg[dest2_s3_reg] <= 1'b1;
            lvt1_reg[dest2_s3_reg] <= 1'b1;
        end
        lvt_rd_reg[0] <= lvt0_reg[idx_s2[0]];
        lvt_rd_reg[1] <= lvt0_reg[idx_s2[1]];
        lvt_rd_reg[2] <= lvt1_reg[idx_s2[2]];
        lvt_rd_reg[3] <= lvt1_reg[idx_s2[3]];
    end

    // Operand select: constant, forwarded word, or the newest bank.
    assign from_var[0] = s3_reg.a_from_var;
    assign from_var[1] = s3_reg.b_from_var;
    assign from_var[2] = s3_reg.c_from_var;
    assign from_var[3] = s3_reg.d_from_var;
    assign konst[0]    = s3_reg.a_operand;
    assign konst[1]    = s3_reg.b_operand;
    assign konst[2]    = s3_reg.c_operand;
    assign konst[3]    = s3_reg.d_operand;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (!from_var[i])
            begin
                opnd[i] = konst[i];
            end
            else if (done_reg && (res_reg.writes == 2'd2)
                     && (idx_s3_reg[i] == fwd_dest2_reg))
            begin
                opnd[i] = res_reg.secondary_value;
            end
            else if (done_reg && (res_reg.writes != 2'd0)
                     && (idx_s3_reg[i] == fwd_dest_reg))
            begin
                opnd[i] = res_reg.primary_value;
            end
            else if (lvt_rd_reg[i])
            begin
                opnd[i] = s_rd[i];
            end
            else
            begin
                opnd[i] = p_rd[i];
            end
        end
    end

    assign a = opnd[0];
    assign b = opnd[1];
    assign c = opnd[2];
    assign d = opnd[3];

    // Shared datapath pieces.
    assign mul_signed = (s3_reg.kind == iralu_pkg::KIND_MUL_LONG) & s3_reg.variant[0];
    assign mul_prod   = $signed({mul_signed & a[31], a}) * $signed({mul_signed & b[31], b});
    assign sum_long   = {a, b} + {c, d};
    assign b_lt32     = (b[31:5] == 27'd0);
    assign d_lt32     = (d[31:5] == 27'd0);
    assign fill       = {32{a[31]}};

    // Immediate-form lsr and asr by zero mean a shift by 32.
    always_comb
    begin
        bs_n = b;
        if ((s3_reg.kind inside {iralu_pkg::KIND_BS_LSR, iralu_pkg::KIND_BS_ASR})
            && s3_reg.variant[0] && (b == 32'd0))
        begin
            bs_n = 32'd32;
        end
    end

    assign bs_zero = (bs_n == 32'd0);
    assign bs_lt32 = (bs_n[31:5] == 27'd0);
    assign bs_le32 = (bs_n <= 32'd32);
    assign lsl_ext = {1'b0, a} << bs_n[5:0];
    assign lsr_ext = {a, 1'b0} >> bs_n[5:0];
    assign asr_val = 32'($signed(a) >>> bs_n[4:0]);
    assign rot64   = {a, a} >> b[4:0];

    always_comb
    begin
        case (s3_reg.variant)
            iralu_pkg::CMP_EQ: cmp_flag = (a == b);
            iralu_pkg::CMP_LT: cmp_flag = (a < b);
            iralu_pkg::CMP_GE: cmp_flag = (a >= b);
            default:           cmp_flag = (a > b);
        endcase
    end

    always_comb
    begin
        p_val = 32'd0;
        s_val = 32'd0;
        w_cnt = 2'd1;
        case (s3_reg.kind)
            iralu_pkg::KIND_AND:  p_val = a & b;
            iralu_pkg::KIND_OR:   p_val = a | b;
            iralu_pkg::KIND_NOT:  p_val = ~a;
            iralu_pkg::KIND_XOR:  p_val = a ^ b;
            iralu_pkg::KIND_ADD:  p_val = a + b;
            iralu_pkg::KIND_ADD_LONG:
            begin
                p_val = sum_long[63:32];
                s_val = sum_long[31:0];
                w_cnt = 2'd2;
            end
            iralu_pkg::KIND_SUB:  p_val = a - b;
            iralu_pkg::KIND_MUL:  p_val = mul_prod[31:0];
            iralu_pkg::KIND_MUL_LONG:
            begin
                p_val = mul_prod[63:32];
                s_val = mul_prod[31:0];
                w_cnt = 2'd2;
            end
            iralu_pkg::KIND_LSL:  p_val = b_lt32 ? (a << b[4:0]) : 32'd0;
            iralu_pkg::KIND_LSR:  p_val = b_lt32 ? (a >> b[4:0]) : 32'd0;
            iralu_pkg::KIND_ASR:  p_val = b_lt32 ? asr_val : fill;
            iralu_pkg::KIND_ROR:  p_val = rot64[31:0];
            iralu_pkg::KIND_BS_LSL:
            begin
                w_cnt = 2'd2;
                if (bs_zero)
                begin
                    p_val = a;
                    s_val = c;
                end
                else if (bs_le32)
                begin
                    p_val = lsl_ext[31:0];
                    s_val = {31'd0, lsl_ext[32]};
                end
            end
            iralu_pkg::KIND_BS_LSR:
            begin
                w_cnt = 2'd2;
                if (bs_zero)
                begin
                    p_val = a;
                    s_val = c;
                end
                else if (bs_le32)
                begin
                    p_val = lsr_ext[32:1];
                    s_val = {31'd0, lsr_ext[0]};
                end
            end
            iralu_pkg::KIND_BS_ASR:
            begin
                w_cnt = 2'd2;
                if (bs_zero)
                begin
                    p_val = a;
                    s_val = c;
                end
                else if (bs_lt32)
                begin
                    p_val = asr_val;
                    s_val = {31'd0, lsr_ext[0]};
                end
                else
                begin
                    p_val = fill;
                    s_val = {31'd0, a[31]};
                end
            end
            iralu_pkg::KIND_BS_ROR:
            begin
                w_cnt = 2'd2;
                if (bs_zero)
                begin
                    p_val = a;
                    s_val = c;
                end
                else
                begin
                    p_val = rot64[31:0];
                    s_val = {31'd0, rot64[31]};
                end
            end
            iralu_pkg::KIND_RRX:
            begin
                p_val = {(c != 32'd0), a[31:1]};
                s_val = {31'd0, a[0]};
                w_cnt = 2'd2;
            end
            iralu_pkg::KIND_CLZ:    p_val = 32'(iralu_pkg::clz32(a));
            iralu_pkg::KIND_CMP:    p_val = {31'd0, cmp_flag};
            iralu_pkg::KIND_COPY:   p_val = a;
            iralu_pkg::KIND_GETBIT: p_val = {31'd0, b_lt32 & a[b[4:0]]};
            iralu_pkg::KIND_SETBIT:
                p_val = d_lt32 ? ((a & ~(32'd1 << d[4:0])) | (c << d[4:0])) : a;
            default:
                w_cnt = 2'd0;
        endcase
    end

    // Write back at the end of the execute stage.
    assign we_p = v_reg[3] & (w_cnt != 2'd0);
    assign we_s = v_reg[3] & (w_cnt == 2'd2);

    always_ff @(posedge clk)
    begin
        res_reg.primary_value   <= p_val;
        res_reg.secondary_value <= s_val;
        res_reg.writes          <= w_cnt;
        fwd_dest_reg            <= dest_s3_reg;
        fwd_dest2_reg           <= dest2_s3_reg;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> src/iralu_idx.sv
// Variable index reduction modulo the file size, two register stages.
module iralu_idx #(
    parameter int VARIABLE_COUNT = 64
) (
    input  logic                              clk,
    input  logic [31:0]                       x,
    output logic [$clog2(VARIABLE_COUNT)-1:0] idx
);

    localparam int IDX_W = $clog2(VARIABLE_COUNT);
    localparam bit IS_POW2 = ((VARIABLE_COUNT & (VARIABLE_COUNT - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic [IDX_W-1:0] x1_reg;
            logic [IDX_W-1:0] x2_reg;

            always_ff @(posedge clk)
            begin
                x1_reg <= x[IDX_W-1:0];
                x2_reg <= x1_reg;
            end

            assign idx = x2_reg;
        end
        else begin : g_recip
            // Floor reciprocal: the quotient estimate is low by at most one.
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / VARIABLE_COUNT);
            localparam logic [31:0] COUNT = 32'(VARIABLE_COUNT);

            logic [63:0] prod;
            logic [31:0] q_reg;
            logic [31:0] x1_reg;
            logic [31:0] qn_reg;
            logic [31:0] x2_reg;
            logic [31:0] rem;
            logic [31:0] rem_fix;

            assign prod = 64'(x) * 64'(RECIP);

            always_ff @(posedge clk)
            begin
                q_reg  <= prod[63:32];
                x1_reg <= x;
                qn_reg <= 32'(q_reg * COUNT);
                x2_reg <= x1_reg;
            end

            assign rem     = x2_reg - qn_reg;
            assign rem_fix = (rem >= COUNT) ? (rem - COUNT) : rem;
            assign idx     = rem_fix[IDX_W-1:0];
        end
    endgenerate

endmodule

>>> src/iralu_mem.sv
// Variable bank: one write port, two read ports with registered read data.
module iralu_mem #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [iralu_pkg::DATA_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr0,
    input  logic [$clog2(DEPTH)-1:0]     raddr1,
    output logic [iralu_pkg::DATA_W-1:0] rdata0,
    output logic [iralu_pkg::DATA_W-1:0] rdata1
);

    logic [iralu_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> src/iralu_checker.sv
// Port checker for the IR ALU, bound to the top level.
`include "ir_alu_with_variable_file_defines.svh"

module iralu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input iralu_pkg::cmd_t    cmd,
    input logic               done,
    input iralu_pkg::result_t result
);

    `IRALU_ASSERT_MSG(a_never_busy, clk, rst_n, !busy, "iralu: busy raised")
    `IRALU_ASSERT_MSG(a_word_returns, clk, rst_n, (start && !busy) |-> ##5 done, "iralu: result word missing")
    `IRALU_ASSERT_MSG(a_no_spurious, clk, rst_n, done |-> $past(start && !busy, 5), "iralu: unrequested result word")
    `IRALU_ASSERT(a_unknown_kind, clk, rst_n, done |-> ((result.writes == 2'd0) == ($past(cmd.kind, 5) > iralu_pkg::KIND_LAST)))
    `IRALU_ASSERT(a_single_write, clk, rst_n, (done && (result.writes == 2'd1)) |-> (result.secondary_value == 32'd0))

endmodule

bind ir_alu_with_variable_file iralu_checker u_iralu_checker (.*);

>>> tb/ir_alu_with_variable_file_tb.sv
// Self-checking testbench of the IR ALU: directed and random words against a predictor.
`timescale 1ns / 1ps

module ir_alu_with_variable_file_tb;
    import iralu_pkg::*;

    localparam int VAR_COUNT     = 64;
    localparam int RANDOM_WORDS  = 900;
    localparam int CALM_WORDS    = 150;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 100000;
    localparam logic [1:0] VARIANT_PLAIN  = 2'd0;
    localparam logic [1:0] VARIANT_SIGNED = 2'd1;
    localparam logic [1:0] VARIANT_IMM    = 2'd1;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      cycle_count;

    class alu_scoreboard;
        logic [31:0] vars [VAR_COUNT];
        bit          written [VAR_COUNT];
        int          written_count;
        result_t     pending_results [$];
        int          mismatches;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function logic [31:0] fetch(logic from_var, logic [31:0] operand);
            return from_var ? vars[operand % VAR_COUNT] : operand;
        endfunction

        function void store(logic [5:0] idx, logic [31:0] val);
            vars[idx % VAR_COUNT] = val;
            if (!written[idx % VAR_COUNT])
            begin
                written[idx % VAR_COUNT] = 1'b1;
                written_count++;
            end
        endfunction

        function logic [31:0] rotate(logic [31:0] v, logic [31:0] n);
            logic [4:0] k;
            k = n[4:0];
            if (k == 5'd0)
            begin
                return v;
            end
            return (v >> k) | (v << (32 - k));
        endfunction

        function logic [31:0] lead_zeros(logic [31:0] v);
            logic [31:0] n;
            n = 32'd0;
            while (n < 32 && v[31 - n] == 1'b0)
            begin
                n++;
            end
            return n;
        endfunction

        // Shifter value in the upper word, carry out (or carry in kept) in the lower.
        function logic [63:0] barrel(logic [4:0] kind, logic [31:0] v, logic [31:0] n,
                                     logic [31:0] cin, logic imm);
            logic [31:0] amt;
            logic [31:0] val;
            logic        cy;
            amt = n;
            if ((kind inside {KIND_BS_LSR, KIND_BS_ASR}) && imm && amt == 0)
            begin
                amt = 32;
            end
            if (amt == 0)
            begin
                return {v, cin};
            end
            case (kind)
                KIND_BS_LSL:
                begin
                    if (amt < 32)
                    begin
                        val = v << amt;
                        cy  = v[32 - amt];
                    end
                    else
                    begin
                        val = 32'd0;
                        cy  = (amt == 32) ? v[0] : 1'b0;
                    end
                end
                KIND_BS_LSR:
                begin
                    if (amt < 32)
                    begin
                        val = v >> amt;
                        cy  = v[amt - 1];
                    end
                    else
                    begin
                        val = 32'd0;
                        cy  = (amt == 32) ? v[31] : 1'b0;
                    end
                end
                KIND_BS_ASR:
                begin
                    if (amt < 32)
                    begin
                        val = $signed(v) >>> amt;
                        cy  = v[amt - 1];
                    end
                    else
                    begin
                        val = {32{v[31]}};
                        cy  = v[31];
                    end
                end
                default:
                begin
                    val = rotate(v, amt);
                    cy  = val[31];
                end
            endcase
            return {val, 31'd0, cy};
        endfunction

        function result_t execute_op(cmd_t w);
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            logic [31:0] d;
            logic [31:0] p;
            logic [31:0] s;
            logic [63:0] wide;
            logic [1:0]  writes;
            result_t     r;
            // read every operand before any write
            a = fetch(w.a_from_var, w.a_operand);
            b = fetch(w.b_from_var, w.b_operand);
            c = fetch(w.c_from_var, w.c_operand);
            d = fetch(w.d_from_var, w.d_operand);
            p = 32'd0;
            s = 32'd0;
            writes = 2'd1;
            case (w.kind)
                KIND_AND:  p = a & b;
                KIND_OR:   p = a | b;
                KIND_NOT:  p = ~a;
                KIND_XOR:  p = a ^ b;
                KIND_ADD:  p = a + b;
                KIND_ADD_LONG:
                begin
                    wide = {a, b} + {c, d};
                    {p, s} = wide;
                    writes = 2'd2;
                end
                KIND_SUB:  p = a - b;
                KIND_MUL:  p = a * b;
                KIND_MUL_LONG:
                begin
                    if (w.variant[0])
                    begin
                        wide = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    end
                    else
                    begin
                        wide = {32'd0, a} * {32'd0, b};
                    end
                    {p, s} = wide;
                    writes = 2'd2;
                end
                KIND_LSL:  p = (b >= 32) ? 32'd0 : (a << b);
                KIND_LSR:  p = (b >= 32) ? 32'd0 : (a >> b);
                KIND_ASR:
                begin
                    if (b >= 32)
                    begin
                        p = {32{a[31]}};
                    end
                    else
                    begin
                        p = $signed(a) >>> b;
                    end
                end
                KIND_ROR:  p = rotate(a, b);
                KIND_BS_LSL, KIND_BS_LSR, KIND_BS_ASR, KIND_BS_ROR:
                begin
                    {p, s} = barrel(w.kind, a, b, c, w.variant[0]);
                    writes = 2'd2;
                end
                KIND_RRX:
                begin
                    p = {c != 32'd0, a[31:1]};
                    s = {31'd0, a[0]};
                    writes = 2'd2;
                end
                KIND_CLZ:  p = lead_zeros(a);
                KIND_CMP:
                begin
                    case (w.variant)
                        CMP_EQ:  p = (a == b) ? 32'd1 : 32'd0;
                        CMP_LT:  p = (a < b)  ? 32'd1 : 32'd0;
                        CMP_GE:  p = (a >= b) ? 32'd1 : 32'd0;
                        default: p = (a > b)  ? 32'd1 : 32'd0;
                    endcase
                end
                KIND_COPY:   p = a;
                KIND_GETBIT: p = (b >= 32) ? 32'd0 : ((a >> b) & 32'd1);
                KIND_SETBIT: p = (d >= 32) ? a : ((a & ~(32'd1 << d)) | (c << d));
                default:     writes = 2'd0;
            endcase
            // secondary write goes last so it wins on a shared destination
            if (writes >= 2'd1)
            begin
                store(w.dest_index, p);
            end
            if (writes == 2'd2)
            begin
                store(w.dest2_index, s);
            end
            r.primary_value   = p;
            r.secondary_value = s;
            r.writes          = writes;
            return r;
        endfunction

        function void note_word(cmd_t w);
            pending_results = {pending_results, execute_op(w)};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("result %h with no word outstanding", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.primary_value !== want.primary_value)
            begin
                flag($sformatf("primary_value exp %h got %h",
                               want.primary_value, got.primary_value));
            end
            if (got.secondary_value !== want.secondary_value)
            begin
                flag($sformatf("secondary_value exp %h got %h",
                               want.secondary_value, got.secondary_value));
            end
            if (got.writes !== want.writes)
            begin
                flag($sformatf("writes exp %0d got %0d", want.writes, got.writes));
            end
        endfunction
    endclass

    alu_scoreboard sb;

    ir_alu_with_variable_file #(
        .VARIABLE_COUNT(VAR_COUNT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** ir_alu_with_variable_file: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    // Hold the word until the block takes it.
    task automatic send_word(input cmd_t w);
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
        sb.note_word(w);
    endtask

    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic cmd_t make_cmd(logic [4:0] kind, int dest, int dest2,
                                      int av, logic [31:0] a, int bv, logic [31:0] b,
                                      int cv, logic [31:0] c, int dv, logic [31:0] d,
                                      logic [1:0] variant);
        cmd_t w;
        w.kind        = kind;
        w.dest_index  = 6'(dest);
        w.dest2_index = 6'(dest2);
        w.a_from_var  = 1'(av);
        w.a_operand   = a;
        w.b_from_var  = 1'(bv);
        w.b_operand   = b;
        w.c_from_var  = 1'(cv);
        w.c_operand   = c;
        w.d_from_var  = 1'(dv);
        w.d_operand   = d;
        w.variant     = variant;
        return w;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd31;
            2:       return 32'd32;
            3:       return 32'd33;
            4:       return 32'd64;
            5:       return $urandom();
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Either the constant or a written variable, with random bits above the index.
    function automatic logic [32:0] operand_of(logic [31:0] konst);
        logic [5:0]  idx;
        logic [31:0] upper;
        if (sb.written_count > 0 && $urandom_range(0, 2) == 0)
        begin
            for (int tries = 0; tries < 8; tries++)
            begin
                idx = 6'($urandom_range(0, VAR_COUNT - 1));
                if (sb.written[idx])
                begin
                    upper = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom() & 32'hFFFF_FFC0);
                    return {1'b1, upper | {26'd0, idx}};
                end
            end
        end
        return {1'b0, konst};
    endfunction

    // Favor a few destinations so that words depend on their neighbors.
    function automatic logic [5:0] rand_dest();
        if ($urandom_range(0, 3) == 0)
        begin
            return 6'($urandom_range(0, VAR_COUNT - 1));
        end
        return 6'($urandom_range(0, 7));
    endfunction

    function automatic cmd_t rand_word();
        cmd_t        w;
        logic        shifting;
        if ($urandom_range(0, 99) < 3)
        begin
            w.kind = 5'($urandom_range(KIND_LAST + 1, 31));
        end
        else
        begin
            w.kind = 5'($urandom_range(0, KIND_LAST));
        end
        w.dest_index  = rand_dest();
        w.dest2_index = rand_dest();
        w.variant     = 2'($urandom_range(0, 3));
        shifting = (w.kind inside {[KIND_LSL:KIND_BS_ROR], KIND_GETBIT});
        {w.a_from_var, w.a_operand} = operand_of(rand_value());
        {w.b_from_var, w.b_operand} = operand_of(shifting ? rand_amount() : rand_value());
        {w.c_from_var, w.c_operand} = operand_of(rand_value());
        {w.d_from_var, w.d_operand} =
            operand_of((w.kind == KIND_SETBIT) ? rand_amount() : rand_value());
        return w;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, back to back
        send_word(make_cmd(KIND_COPY, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_COPY, 1, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        // index above the file size wraps to variable 0
        send_word(make_cmd(KIND_NOT, 2, 0, 1, 32'hFFFF_FFC0, 0, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_AND, 3, 0, 1, 0, 0, 32'h0F0F_0F0F, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_OR, 4, 0, 1, 1, 1, 3, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_XOR, 5, 0, 1, 0, 0, 32'h1234_5678, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_ADD, 6, 0, 1, 0, 0, 1, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_SUB, 7, 0, 0, 0, 0, 1, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_MUL, 8, 0, 1, 0, 1, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_ADD_LONG, 9, 10, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                           0, 0, 0, 1, VARIANT_PLAIN));
        send_word(make_cmd(KIND_MUL_LONG, 11, 12, 1, 0, 1, 1, 0, 0, 0, 0, VARIANT_SIGNED));
        send_word(make_cmd(KIND_LSL, 13, 0, 1, 0, 0, 32, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_LSR, 14, 0, 1, 0, 0, 33, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_ASR, 15, 0, 1, 1, 0, 40, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_ROR, 16, 0, 0, 32'h1234_5678, 0, 36, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_BS_LSL, 17, 18, 1, 0, 0, 32, 0, 0, 0, 0, VARIANT_PLAIN));
        // immediate form with amount zero shifts by 32
        send_word(make_cmd(KIND_BS_LSR, 19, 20, 1, 1, 0, 0, 0, 0, 0, 0, VARIANT_IMM));
        // register form with amount zero keeps the carry in
        send_word(make_cmd(KIND_BS_ASR, 21, 22, 1, 1, 0, 0, 0, 32'hDEAD_BEEF,
                           0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_BS_ROR, 23, 24, 0, 32'h8000_0001, 0, 64, 0, 0, 0, 0,
                           VARIANT_PLAIN));
        send_word(make_cmd(KIND_RRX, 25, 26, 0, 3, 0, 0, 1, 1, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_CLZ, 27, 0, 0, 0, 0, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_CMP, 28, 0, 1, 0, 1, 1, 0, 0, 0, 0, CMP_GT));
        send_word(make_cmd(KIND_GETBIT, 29, 0, 1, 0, 0, 32, 0, 0, 0, 0, VARIANT_PLAIN));
        // the whole set-bit value shifts, not just its low bit
        send_word(make_cmd(KIND_SETBIT, 30, 0, 0, 0, 0, 0, 0, 3, 0, 30, VARIANT_PLAIN));
        send_word(make_cmd(5'd31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, VARIANT_PLAIN));
        send_word(make_cmd(KIND_ADD_LONG, 31, 31, 1, 28, 1, 27, 1, 0, 1, 4, VARIANT_PLAIN));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
            begin
                drain();
            end
            if (i < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 3) == 0)
            begin
                idle($urandom_range(1, 6));
            end
            send_word(rand_word());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("** ir_alu_with_variable_file: PASSED **");
        end
        else
        begin
            $display("** ir_alu_with_variable_file: FAILED **");
        end
        $finish;
    end

endmodule
